// ===== rtl/spq_pkg.sv =====
package spq_pkg;

	localparam int CAPACITY_DEF  = 64;
	localparam int ID_BITS_DEF   = 10;
	localparam int DIST_BITS_DEF = 32;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_INS  = 2'b10
	} spq_state_t;

	typedef struct packed {
		logic accept;
		logic insert;
		logic load;
	} spq_cmd_t;

	typedef struct packed {
		logic out_free;
	} spq_status_t;

endpackage

// ===== rtl/spq_if.sv =====
interface spq_req_if #(
	parameter int ID_BITS   = 10,
	parameter int DIST_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 op;
	logic [ID_BITS-1:0]   node_id;
	logic [DIST_BITS-1:0] distance;

	modport source (output valid, op, node_id, distance, input ready);
	modport sink (input valid, op, node_id, distance, output ready);
endinterface

interface spq_rsp_if #(
	parameter int ID_BITS   = 10,
	parameter int DIST_BITS = 32,
	parameter int CNT_BITS  = 7
);
	logic                 valid;
	logic                 ready;
	logic                 is_empty;
	logic [ID_BITS-1:0]   head_id;
	logic [DIST_BITS-1:0] head_distance;
	logic [CNT_BITS-1:0]  entry_count;
	logic                 overflow;

	modport source (output valid, is_empty, head_id, head_distance, entry_count, overflow,
		input ready);
	modport sink (input valid, is_empty, head_id, head_distance, entry_count, overflow,
		output ready);
endinterface

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl
	import spq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  spq_status_t status,
	output spq_cmd_t    cmd
);

	spq_state_t state_q;
	logic       pend_q;

	assign req_ready  = (state_q == ST_IDLE) && (!pend_q || status.out_free);
	assign cmd.accept = req_valid && req_ready;
	assign cmd.insert = (state_q == ST_INS);
	assign cmd.load   = (state_q == ST_IDLE) && pend_q && status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						pend_q <= 1'b0;
					end
					if (cmd.accept) begin
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					pend_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/spq_dpath.sv =====
module spq_dpath
	import spq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int DIST_BITS = DIST_BITS_DEF,
	parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_cmd_t             cmd,
	output spq_status_t          status,
	input  logic                 in_op,
	input  logic [ID_BITS-1:0]   in_id,
	input  logic [DIST_BITS-1:0] in_dist,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_empty,
	output logic [ID_BITS-1:0]   out_id,
	output logic [DIST_BITS-1:0] out_dist,
	output logic [CNT_BITS-1:0]  out_count,
	output logic                 out_ovf
);

	localparam int LV = $clog2(CAPACITY);

	logic [ID_BITS-1:0]   id_q   [CAPACITY];
	logic [DIST_BITS-1:0] dist_q [CAPACITY];
	logic [CAPACITY-1:0]  vld_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 op_q;
	logic                 ovf_q;
	logic [ID_BITS-1:0]   nid_q;
	logic [DIST_BITS-1:0] ndist_q;
	logic                 out_valid_q;

	logic [CAPACITY-1:0]  match;
	logic [CAPACITY-1:0]  kill;
	logic [CAPACITY-1:0]  pre [0:LV];
	logic [CAPACITY-1:0]  lt;
	logic                 found;
	logic                 do_ins;

	assign found  = |match;
	assign do_ins = cmd.insert && (op_q == OP_INSERT) && !ovf_q;
	assign kill   = (in_op == OP_DEQUEUE) ? {{(CAPACITY-1){1'b0}}, vld_q[0]} : match;
	assign pre[0] = kill;

	// prefix or of the kill vector: cells at and above the removed entry shift down
	for (genvar l = 0; l < LV; l++) begin : g_lvl
		for (genvar i = 0; i < CAPACITY; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign pre[l+1][i] = pre[l][i] | pre[l][i-(1<<l)];
			end else begin : g_pass
				assign pre[l+1][i] = pre[l][i];
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                 lt_prev;
		logic [ID_BITS-1:0]   up_id;
		logic [DIST_BITS-1:0] up_dist;
		logic                 up_vld;
		logic [ID_BITS-1:0]   lo_id;
		logic [DIST_BITS-1:0] lo_dist;
		logic                 lo_vld;

		assign match[i] = vld_q[i] && (id_q[i] == in_id);
		assign lt[i]    = vld_q[i] && (ndist_q > dist_q[i]);

		if (i == 0) begin : g_first
			assign lt_prev = 1'b1;
			assign lo_id   = id_q[i];
			assign lo_dist = dist_q[i];
			assign lo_vld  = vld_q[i];
		end else begin : g_lo
			assign lt_prev = lt[i-1];
			assign lo_id   = id_q[i-1];
			assign lo_dist = dist_q[i-1];
			assign lo_vld  = vld_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign up_id   = id_q[i];
			assign up_dist = dist_q[i];
			assign up_vld  = 1'b0;
		end else begin : g_up
			assign up_id   = id_q[i+1];
			assign up_dist = dist_q[i+1];
			assign up_vld  = vld_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.accept && pre[LV][i]) begin
				id_q[i]   <= up_id;
				dist_q[i] <= up_dist;
			end else if (do_ins && !lt[i]) begin
				if (lt_prev) begin
					id_q[i]   <= nid_q;
					dist_q[i] <= ndist_q;
				end else begin
					id_q[i]   <= lo_id;
					dist_q[i] <= lo_dist;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (cmd.accept && pre[LV][i]) begin
				vld_q[i] <= up_vld;
			end else if (do_ins && !lt[i]) begin
				vld_q[i] <= lt_prev ? 1'b1 : lo_vld;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept && found) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.accept && (in_op == OP_DEQUEUE) && vld_q[0]) begin
			cnt_q <= cnt_q - 1'b1;
		end else if (do_ins) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q    <= in_op;
			ovf_q   <= (in_op == OP_INSERT) && !found && (cnt_q == CNT_BITS'(CAPACITY));
			nid_q   <= in_id;
			ndist_q <= in_dist;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_empty <= (cnt_q == '0);
			out_id    <= vld_q[0] ? id_q[0] : '0;
			out_dist  <= vld_q[0] ? dist_q[0] : '0;
			out_count <= cnt_q;
			out_ovf   <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule

// ===== rtl/sorted_priority_queue_with_update.sv =====
// Sorted minimum priority queue of (node id, distance) pairs with update by id.
// Request channel (req): op 0 inserts or updates node_id with distance, op 1
// removes the head. An insert first drops any entry with the same id, then
// places the pair ahead of all entries of greater or equal distance.
// Response channel (rsp): one word per request, showing the queue after it:
// is_empty, head_id, head_distance, entry_count and overflow (an insert of a
// new id into a full queue, which is dropped).
// The queue is a row of CAPACITY register cells. For each request, the
// acceptance edge shifts out the matching or head entry, the next edge
// shifts the new pair in. The response is loaded in the idle state once the
// output register is free, and the next request can be accepted in that same
// cycle; a new request is never taken while the last one is being shifted in.
// When the receiver stalls, the response waits in its output register; one
// more request is still taken and processed, then req.ready stays low until
// the waiting word is taken.
// Reset empties the queue at once; no clearing pass is needed.
module sorted_priority_queue_with_update
	import spq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int DIST_BITS = DIST_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	spq_cmd_t    cmd;
	spq_status_t status;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	spq_dpath #(
		.CAPACITY  (CAPACITY),
		.ID_BITS   (ID_BITS),
		.DIST_BITS (DIST_BITS),
		.CNT_BITS  (CNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_op     (req.op),
		.in_id     (req.node_id),
		.in_dist   (req.distance),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_empty (rsp.is_empty),
		.out_id    (rsp.head_id),
		.out_dist  (rsp.head_distance),
		.out_count (rsp.entry_count),
		.out_ovf   (rsp.overflow)
	);

endmodule

// ===== rtl/spq_check.sv =====
module spq_check
	import spq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int ID_BITS   = ID_BITS_DEF,
	parameter int DIST_BITS = DIST_BITS_DEF,
	parameter int CNT_BITS  = $clog2(CAPACITY + 1)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic                 rsp_empty,
	input logic [ID_BITS-1:0]   rsp_id,
	input logic [DIST_BITS-1:0] rsp_dist,
	input logic [CNT_BITS-1:0]  rsp_count,
	input logic                 rsp_ovf
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_count <= CNT_BITS'(CAPACITY)))
		else $error("entry count above capacity");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_empty == (rsp_count == '0)))
		else $error("empty flag disagrees with count");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_empty) |-> ((rsp_id == '0) && (rsp_dist == '0)))
		else $error("empty queue shows a head");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_ovf) |-> (rsp_count == CNT_BITS'(CAPACITY)))
		else $error("overflow while not full");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_count) && $stable(rsp_id)))
		else $error("stalled word changed");

endmodule

bind sorted_priority_queue_with_update spq_check #(
	.CAPACITY  (CAPACITY),
	.ID_BITS   (ID_BITS),
	.DIST_BITS (DIST_BITS)
) u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_empty (rsp.is_empty),
	.rsp_id    (rsp.head_id),
	.rsp_dist  (rsp.head_distance),
	.rsp_count (rsp.entry_count),
	.rsp_ovf   (rsp.overflow)
);

// ===== tb/sorted_priority_queue_with_update_test.sv =====
module sorted_priority_queue_with_update_test;
	import spq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [ID_BITS_DEF-1:0] node_t;
	typedef logic [DIST_BITS_DEF-1:0] dist_t;
	typedef logic [6:0] count_t;

	typedef struct packed {
		logic   is_empty;
		node_t  head_id;
		dist_t  head_distance;
		count_t entry_count;
		logic   overflow;
	} head_word_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if #(.ID_BITS(ID_BITS_DEF), .DIST_BITS(DIST_BITS_DEF)) req ();
	spq_rsp_if #(.ID_BITS(ID_BITS_DEF), .DIST_BITS(DIST_BITS_DEF), .CNT_BITS(7)) rsp ();

	sorted_priority_queue_with_update #(
		.CAPACITY (CAPACITY_DEF),
		.ID_BITS  (ID_BITS_DEF),
		.DIST_BITS(DIST_BITS_DEF)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// shadow of the queue contents, in ascending distance order
	node_t q_ids[CAPACITY_DEF];
	dist_t q_dists[CAPACITY_DEF];
	int q_count;

	head_word_t awaited_heads[$];
	int errors;
	bit steady;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void pull_entry(input int pos);
		for (int i = pos; i < q_count - 1; i++) begin
			q_ids[i] = q_ids[i + 1];
			q_dists[i] = q_dists[i + 1];
		end
		q_count--;
	endfunction

	function automatic head_word_t queue_apply(input logic op, input node_t id,
		input dist_t dist_val);
		head_word_t w;
		int pos;
		logic dropped;
		dropped = 1'b0;
		if (op == OP_INSERT) begin
			pos = -1;
			for (int i = 0; i < q_count; i++) begin
				if (pos < 0 && q_ids[i] == id)
					pos = i;
			end
			if (pos >= 0)
				pull_entry(pos);
			if (q_count >= CAPACITY_DEF) begin
				dropped = 1'b1;
			end else begin
				pos = 0;
				while (pos < q_count && dist_val > q_dists[pos])
					pos++;
				for (int i = q_count; i > pos; i--) begin
					q_ids[i] = q_ids[i - 1];
					q_dists[i] = q_dists[i - 1];
				end
				q_ids[pos] = id;
				q_dists[pos] = dist_val;
				q_count++;
			end
		end else if (q_count > 0) begin
			pull_entry(0);
		end
		w.is_empty = (q_count == 0);
		w.head_id = (q_count == 0) ? '0 : q_ids[0];
		w.head_distance = (q_count == 0) ? '0 : q_dists[0];
		w.entry_count = count_t'(q_count);
		w.overflow = dropped;
		return w;
	endfunction

	task automatic send_word(input logic op, input node_t id, input dist_t dist_val);
		bit taken;
		while (!steady && $urandom_range(99) < 30) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.node_id <= id;
		req.distance <= dist_val;
		do begin
			@(negedge clk);
			taken = req.ready;
			@(posedge clk);
		end while (!taken);
		awaited_heads.push_back(queue_apply(op, id, dist_val));
	endtask

	task automatic flag_mismatch(input string field, input logic [31:0] want,
		input logic [31:0] got);
		errors++;
		$display("%0t %s: expected %0h actual %0h", $time, field, want, got);
	endtask

	// response side: random stalls; words are sampled on the falling clock edge
	always @(posedge clk)
		rsp.ready <= steady || ($urandom_range(99) >= 30);

	always @(negedge clk) begin
		head_word_t want;
		if (arst_n && rsp.valid === 1'b1 && rsp.ready) begin
			if (awaited_heads.size() == 0) begin
				errors++;
				$display("%0t unexpected word: head_id %0h head_distance %0h count %0d",
					$time, rsp.head_id, rsp.head_distance, rsp.entry_count);
			end else begin
				want = awaited_heads.pop_front();
				if (rsp.is_empty !== want.is_empty)
					flag_mismatch("is_empty", want.is_empty, rsp.is_empty);
				if (rsp.head_id !== want.head_id)
					flag_mismatch("head_id", want.head_id, rsp.head_id);
				if (rsp.head_distance !== want.head_distance)
					flag_mismatch("head_distance", want.head_distance, rsp.head_distance);
				if (rsp.entry_count !== want.entry_count)
					flag_mismatch("entry_count", want.entry_count, rsp.entry_count);
				if (rsp.overflow !== want.overflow)
					flag_mismatch("overflow", want.overflow, rsp.overflow);
			end
		end
	end

	task automatic test_ordering_and_update();
		send_word(OP_DEQUEUE, 10'd0, '0);
		send_word(OP_INSERT, 10'd5, 32'd100);
		send_word(OP_INSERT, 10'd1023, 32'hFFFF_FFFF);
		send_word(OP_INSERT, 10'd0, 32'd0);
		// equal distance goes ahead
		send_word(OP_INSERT, 10'd7, 32'd100);
		send_word(OP_INSERT, 10'd5, 32'd50);
		send_word(OP_INSERT, 10'd0, 32'd200);
		send_word(OP_INSERT, 10'd1023, 32'd0);
		send_word(OP_INSERT, 10'd12, 32'd0);
		send_word(OP_INSERT, 10'd12, 32'd0);
		send_word(OP_INSERT, 10'd7, 32'hFFFF_FFFF);
		for (int i = 0; i < 6; i++)
			send_word(OP_DEQUEUE, node_t'(i), '1);
	endtask

	task automatic test_full_queue();
		for (int i = 0; i < CAPACITY_DEF; i++)
			send_word(OP_INSERT, node_t'(1023 - 3 * i), dist_t'($urandom_range(1000)));
		send_word(OP_INSERT, 10'd5, 32'd1);
		// id already present, so the update still fits
		send_word(OP_INSERT, 10'd1023, 32'd0);
		send_word(OP_INSERT, node_t'(1023 - 3 * (CAPACITY_DEF - 1)), 32'hFFFF_FFFF);
		send_word(OP_INSERT, 10'd6, 32'd0);
		send_word(OP_DEQUEUE, 10'd0, '0);
		send_word(OP_INSERT, 10'd7, 32'd500);
		for (int i = 0; i <= CAPACITY_DEF; i++)
			send_word(OP_DEQUEUE, node_t'($urandom_range(1023)), dist_t'($urandom));
	endtask

	task automatic test_relaxation(input int items);
		bit filling;
		logic op;
		node_t id;
		dist_t dist_val;
		int pool_base;
		int pick;
		filling = 1'b1;
		pool_base = $urandom_range(944);
		for (int n = 0; n < items; n++) begin
			steady = (n >= items * 2 / 5 && n < items * 3 / 5);
			if (filling && q_count == CAPACITY_DEF && $urandom_range(5) == 0) begin
				filling = 1'b0;
			end else if (!filling && q_count == 0 && $urandom_range(2) == 0) begin
				filling = 1'b1;
				pool_base = $urandom_range(944);
			end
			op = ($urandom_range(99) < (filling ? 15 : 75)) ? OP_DEQUEUE : OP_INSERT;
			if ($urandom_range(99) < 70)
				id = node_t'(pool_base + $urandom_range(79));
			else
				id = node_t'($urandom_range(1023));
			pick = $urandom_range(99);
			if (pick < 40)
				dist_val = dist_t'($urandom_range(15));
			else if (pick < 70)
				dist_val = (q_count > 0 ? q_dists[0] : '0) + dist_t'($urandom_range(255));
			else if (pick < 90)
				dist_val = dist_t'($urandom);
			else
				dist_val = $urandom_range(1) ? '1 : '0;
			send_word(op, id, dist_val);
		end
		steady = 1'b0;
	endtask

	initial begin
		errors = 0;
		q_count = 0;
		steady = 1'b0;
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.op <= OP_INSERT;
		req.node_id <= '0;
		req.distance <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_ordering_and_update();
		test_full_queue();
		test_relaxation(450);
		req.valid <= 1'b0;
		while (awaited_heads.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("sorted_priority_queue_with_update: match");
		end else begin
			$display("sorted_priority_queue_with_update: mismatch");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("sorted_priority_queue_with_update: mismatch");
		$finish;
	end

endmodule
